// ===== rtl/stmc_pkg.sv =====
// Shared types, codes and constants of the segment translation micro-cache.
package stmc_pkg;

	localparam int CACHE_ENTRIES_DEF = 16;
	localparam int NUM_CACHES_DEF = 4;

	localparam int OFFSET_W = 18;
	localparam int BOUND_W = 14;
	localparam int ADDR_W = 24;
	localparam int RING_W = 3;
	localparam int SEG_W = 15;
	localparam int SEL_W = 2;
	localparam int BOUND_SHIFT = 4;

	localparam int APB_ADDR_W = 3;
	localparam int APB_DATA_W = 32;
	localparam logic [APB_ADDR_W-3:0] REG_PAGE_MASK = '0;
	localparam logic [OFFSET_W-1:0] PAGE_MASK_RESET = 18'o776000;

	typedef enum logic [1:0] {
		OP_INVALIDATE = 2'd0,
		OP_SAVE       = 2'd1,
		OP_CHECK      = 2'd2
	} func_t;

	typedef struct packed {
		logic [OFFSET_W-1:0] offset;
		logic [BOUND_W-1:0]  bound;
		logic [ADDR_W-1:0]   address;
		logic [RING_W-1:0]   ring;
		logic                prot;
		logic                paged;
	} entry_t;

	typedef struct packed {
		logic                hit;
		logic [BOUND_W-1:0]  bound;
		logic                prot;
		logic [ADDR_W-1:0]   address;
		logic [RING_W-1:0]   ring;
		logic                paged;
	} result_t;

endpackage

// ===== rtl/segment_translation_microcache_core.sv =====
// Segment translation micro-cache: direct-mapped lookup, save and invalidate.
//
// Requests arrive on a valid/ready channel (func, cache_sel, segment_number,
// word_offset and the save fields); one result per request leaves on a
// valid/ready channel (hit and the stored fields, all zero on a miss).
// Saves and invalidates also return a result, with hit low and zero data.
// A request is taken every cycle unless the receiver stalls; its result passes
// the lookup stage, then the output register. The entry memory is written and
// read at the accept edge; a request sees every earlier save and invalidate.
// The page mask sits behind an APB port at byte address 0; the user must write
// it only while no request is in flight, which the block does not enforce.
// Reset clears all valid flags and sets the page mask to 0776000 octal;
// entry contents are not cleared, no warm-up is needed.
// When the receiver stalls, the result is held in the output register and
// one more request can sit in the lookup stage; after that in_ready drops
// until the result is taken.
module segment_translation_microcache_core #(
	parameter int CACHE_ENTRIES = stmc_pkg::CACHE_ENTRIES_DEF,
	parameter int NUM_CACHES = stmc_pkg::NUM_CACHES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [stmc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [stmc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [stmc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	input  logic                                in_valid,
	output logic                                in_ready,
	input  logic [1:0]                          func,
	input  logic [stmc_pkg::SEL_W-1:0]          cache_sel,
	input  logic [stmc_pkg::SEG_W-1:0]          segment_number,
	input  logic [stmc_pkg::OFFSET_W-1:0]       word_offset,
	input  logic [stmc_pkg::BOUND_W-1:0]        seg_bound_in,
	input  logic                                prot_bit_in,
	input  logic [stmc_pkg::ADDR_W-1:0]         base_address_in,
	input  logic [stmc_pkg::RING_W-1:0]         ring_in,
	input  logic                                paged_in,
	output logic                                out_valid,
	input  logic                                out_ready,
	output logic                                hit,
	output logic [stmc_pkg::BOUND_W-1:0]        seg_bound_out,
	output logic                                prot_bit_out,
	output logic [stmc_pkg::ADDR_W-1:0]         base_address_out,
	output logic [stmc_pkg::RING_W-1:0]         ring_out,
	output logic                                paged_out
);

	localparam int DEPTH = CACHE_ENTRIES * NUM_CACHES;
	localparam int IDX_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

	logic [stmc_pkg::OFFSET_W-1:0] page_mask;
	stmc_pkg::func_t               func_in;
	logic                          accept;
	logic                          advance;
	logic                          in_range;
	logic [IDX_W-1:0]              idx;
	stmc_pkg::entry_t              wr_entry;
	stmc_pkg::entry_t              rd_entry;
	logic                          rd_valid;
	stmc_pkg::result_t             result;

	logic                          v_s1;
	stmc_pkg::func_t               func_s1;
	logic [stmc_pkg::OFFSET_W-1:0] offset_s1;
	logic                          out_valid_q;
	stmc_pkg::result_t             res_q;

	stmc_apb u_apb (
		.clk       (clk),
		.arst_n    (arst_n),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready),
		.page_mask (page_mask)
	);

	assign func_in = stmc_pkg::func_t'(func);
	assign advance = v_s1 && (!out_valid_q || out_ready);
	assign in_ready = !v_s1 || advance;
	assign accept = in_valid && in_ready;

	assign in_range = (4'(cache_sel) < 4'(NUM_CACHES))
		&& (16'(segment_number) < 16'(CACHE_ENTRIES));
	assign idx = IDX_W'(32'(cache_sel) * 32'(CACHE_ENTRIES) + 32'(segment_number));

	assign wr_entry.offset = word_offset;
	assign wr_entry.bound = seg_bound_in;
	assign wr_entry.address = base_address_in;
	assign wr_entry.ring = ring_in;
	assign wr_entry.prot = prot_bit_in;
	assign wr_entry.paged = paged_in;

	stmc_array #(
		.DEPTH (DEPTH),
		.IDX_W (IDX_W)
	) u_array (
		.clk      (clk),
		.arst_n   (arst_n),
		.wr_en    (accept && (func_in == stmc_pkg::OP_SAVE) && in_range),
		.rd_en    (accept && (func_in == stmc_pkg::OP_CHECK)),
		.inv_all  (accept && (func_in == stmc_pkg::OP_INVALIDATE)),
		.in_range (in_range),
		.idx      (idx),
		.wr_entry (wr_entry),
		.rd_entry (rd_entry),
		.rd_valid (rd_valid)
	);

	stmc_hit u_hit (
		.func        (func_s1),
		.offset      (offset_s1),
		.page_mask   (page_mask),
		.entry       (rd_entry),
		.entry_valid (rd_valid),
		.result      (result)
	);

	always_ff @(posedge clk) begin
		if (accept) begin
			func_s1 <= func_in;
			offset_s1 <= word_offset;
		end
		if (advance) begin
			res_q <= result;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (accept) begin
				v_s1 <= 1'b1;
			end else if (advance) begin
				v_s1 <= 1'b0;
			end
			if (advance) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign out_valid = out_valid_q;
	assign hit = res_q.hit;
	assign seg_bound_out = res_q.bound;
	assign prot_bit_out = res_q.prot;
	assign base_address_out = res_q.address;
	assign ring_out = res_q.ring;
	assign paged_out = res_q.paged;

`ifndef SYNTHESIS
	// A miss never carries stale entry data.
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !hit |-> seg_bound_out == '0 && base_address_out == '0
			&& ring_out == '0 && !prot_bit_out && !paged_out)
		else $error("miss result carries nonzero data");

	// With both stages full and the receiver stalled, no request may enter.
	assert property (@(posedge clk) disable iff (!arst_n)
		v_s1 && out_valid_q && !out_ready |-> !in_ready)
		else $error("request accepted while pipeline is blocked");

	// A request leaving the lookup stage always produces a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance |=> out_valid_q)
		else $error("lookup result lost");

	// Only a check can report a hit.
	assert property (@(posedge clk) disable iff (!arst_n)
		advance && func_s1 != stmc_pkg::OP_CHECK |=> !res_q.hit)
		else $error("hit reported for a non-check request");
`endif

endmodule

// ===== rtl/stmc_apb.sv =====
// APB register block holding the page mask.
module stmc_apb (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                psel,
	input  logic                                penable,
	input  logic                                pwrite,
	input  logic [stmc_pkg::APB_ADDR_W-1:0]     paddr,
	input  logic [stmc_pkg::APB_DATA_W-1:0]     pwdata,
	output logic [stmc_pkg::APB_DATA_W-1:0]     prdata,
	output logic                                pready,
	output logic [stmc_pkg::OFFSET_W-1:0]       page_mask
);

	logic [stmc_pkg::OFFSET_W-1:0] page_mask_q;
	logic                          reg_sel;

	assign reg_sel = (paddr[stmc_pkg::APB_ADDR_W-1:2] == stmc_pkg::REG_PAGE_MASK);
	assign pready = 1'b1;
	assign page_mask = page_mask_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			page_mask_q <= stmc_pkg::PAGE_MASK_RESET;
		end else if (psel && penable && pwrite && reg_sel) begin
			page_mask_q <= pwdata[stmc_pkg::OFFSET_W-1:0];
		end
	end

	always_comb begin
		prdata = '0;
		if (reg_sel) begin
			prdata = stmc_pkg::APB_DATA_W'(page_mask_q);
		end
	end

endmodule

// ===== rtl/stmc_array.sv =====
// Entry memory with registered read and per-entry valid flags.
module stmc_array #(
	parameter int DEPTH = stmc_pkg::CACHE_ENTRIES_DEF * stmc_pkg::NUM_CACHES_DEF,
	parameter int IDX_W = 6
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               wr_en,
	input  logic               rd_en,
	input  logic               inv_all,
	input  logic               in_range,
	input  logic [IDX_W-1:0]   idx,
	input  stmc_pkg::entry_t   wr_entry,
	output stmc_pkg::entry_t   rd_entry,
	output logic               rd_valid
);

	stmc_pkg::entry_t mem [DEPTH];
	logic [DEPTH-1:0] valid_q;
	stmc_pkg::entry_t rd_entry_q;
	logic             rd_valid_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[idx] <= wr_entry;
		end
		if (rd_en) begin
			rd_entry_q <= mem[idx];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			rd_valid_q <= 1'b0;
		end else begin
			if (inv_all) begin
				valid_q <= '0;
			end else if (wr_en) begin
				valid_q[idx] <= 1'b1;
			end
			if (rd_en) begin
				rd_valid_q <= in_range && valid_q[idx];
			end
		end
	end

	assign rd_entry = rd_entry_q;
	assign rd_valid = rd_valid_q;

endmodule

// ===== rtl/stmc_hit.sv =====
// Hit logic: page and bound checks on the fetched entry.
module stmc_hit (
	input  stmc_pkg::func_t                func,
	input  logic [stmc_pkg::OFFSET_W-1:0]  offset,
	input  logic [stmc_pkg::OFFSET_W-1:0]  page_mask,
	input  stmc_pkg::entry_t               entry,
	input  logic                           entry_valid,
	output stmc_pkg::result_t              result
);

	logic                         page_ok;
	logic                         bound_ok;
	logic [stmc_pkg::BOUND_W-1:0] offset_units;

	assign offset_units = offset[stmc_pkg::OFFSET_W-1:stmc_pkg::BOUND_SHIFT];
	assign page_ok = !entry.paged || ((entry.offset & page_mask) == (offset & page_mask));
	assign bound_ok = (offset_units <= entry.bound);

	always_comb begin
		result = '0;
		case (func)
			stmc_pkg::OP_CHECK: begin
				if (entry_valid && page_ok && bound_ok) begin
					result.hit = 1'b1;
					result.bound = entry.bound;
					result.prot = entry.prot;
					result.address = entry.address;
					result.ring = entry.ring;
					result.paged = entry.paged;
				end
			end
			default: begin
				result = '0;
			end
		endcase
	end

endmodule
